[design/hks_pkg.sv]
// hks_pkg: types, codes and constants shared by the held key set unit
// no dependencies; compiled first

package hks_pkg;

	localparam int DEFAULT_CAPACITY = 20;
	localparam int KIND_W           = 2;
	localparam int KEY_W            = 8;
	localparam int COUNT_OUT_W      = 5;

	localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_UPDATE
	} hks_state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} hks_cmd_t;

endpackage

[design/hks_if.sv]
// hks_in_if / hks_out_if: valid-ready channels for events and results
// depends on hks_pkg

interface hks_in_if import hks_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key_code;

	modport source (output valid, output kind, output key_code, input ready);
	modport sink   (input valid, input kind, input key_code, output ready);
endinterface

interface hks_out_if import hks_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   was_present;
	logic                   dropped_full;
	logic [COUNT_OUT_W-1:0] held_count;

	modport source (output valid, output was_present, output dropped_full,
		output held_count, input ready);
	modport sink   (input valid, input was_present, input dropped_full,
		input held_count, output ready);
endinterface

[design/hks_ctrl.sv]
// hks_ctrl: sequencer for accept, compare and update of one event
// depends on hks_pkg

module hks_ctrl import hks_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output hks_cmd_t cmd
);

	hks_state_t state_q;
	hks_state_t state_nxt;
	logic       out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_COMPARE;
			end
			ST_COMPARE: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.compare = (state_q == ST_COMPARE);
		cmd.update  = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[design/hks_datapath.sv]
// hks_datapath: held key registers, parallel compare, compaction and result register
// depends on hks_pkg

module hks_datapath import hks_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hks_cmd_t               cmd,
	input  logic [KIND_W-1:0]      kind,
	input  logic [KEY_W-1:0]       key_code,
	output logic                   was_present,
	output logic                   dropped_full,
	output logic [COUNT_OUT_W-1:0] held_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [KIND_W-1:0]      kind_q;
	logic [KEY_W-1:0]       code_q;
	logic [KEY_W-1:0]       entries_q [CAPACITY];
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_nxt;
	logic [CAPACITY-1:0]    match_cmp;
	logic [CAPACITY-1:0]    match_s1;
	logic [CAPACITY-1:0]    at_or_after;
	logic                   present;
	logic                   full;
	logic                   do_append;
	logic                   do_remove;
	logic                   drop;
	logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
	logic                   was_present_q;
	logic                   dropped_full_q;
	logic [COUNT_OUT_W-1:0] held_count_q;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			assign match_cmp[gi]   = (entries_q[gi] == code_q) && (CNT_W'(gi) < count_q);
			assign at_or_after[gi] = |match_s1[gi:0];

			if (gi < CAPACITY - 1) begin : g_shift
				always_ff @(posedge clk) begin
					if (cmd.update) begin
						if (do_remove && at_or_after[gi]) begin
							entries_q[gi] <= entries_q[gi+1];
						end else if (do_append && count_q == CNT_W'(gi)) begin
							entries_q[gi] <= code_q;
						end
					end
				end
			end else begin : g_last
				always_ff @(posedge clk) begin
					if (cmd.update && do_append && count_q == CNT_W'(gi)) begin
						entries_q[gi] <= code_q;
					end
				end
			end
		end
	endgenerate

	always_comb begin
		present   = |match_s1;
		full      = (count_q == CNT_W'(CAPACITY));
		do_append = (kind_q == KIND_PRESS) && !present && !full;
		do_remove = (kind_q == KIND_RELEASE) && present;
		drop      = (kind_q == KIND_PRESS) && !present && full;
		count_nxt = count_q;
		if (do_append) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_remove) begin
			count_nxt = count_q - CNT_W'(1);
		end
		count_ext = (CNT_W+COUNT_OUT_W)'(count_nxt);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			code_q <= key_code;
		end
		if (cmd.compare) begin
			match_s1 <= match_cmp;
		end
		if (cmd.update) begin
			was_present_q  <= present;
			dropped_full_q <= drop;
			held_count_q   <= count_ext[COUNT_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			count_q <= count_nxt;
		end
	end

	assign was_present  = was_present_q;
	assign dropped_full = dropped_full_q;
	assign held_count   = held_count_q;

endmodule

[design/held_key_set_unit.sv]
// held_key_set_unit: ordered set of held key codes with press, release and query
// sequence: the event is registered on accept, compared in ST_COMPARE, and its result registered in ST_UPDATE
// a new event is accepted only in ST_IDLE, once the previous event has been updated
// the update waits while a previous result has not been taken
// reset: asynchronous, clears the entry count and the sequencer; entries are not cleared
// depends on hks_pkg, hks_if, hks_ctrl, hks_datapath

module held_key_set_unit import hks_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic  clk,
	input  logic  arst_n,
	hks_in_if.sink    in_port,
	hks_out_if.source out_port
);

	hks_cmd_t cmd;

	hks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_port.valid),
		.in_ready  (in_port.ready),
		.out_valid (out_port.valid),
		.out_ready (out_port.ready),
		.cmd       (cmd)
	);

	hks_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (in_port.kind),
		.key_code     (in_port.key_code),
		.was_present  (out_port.was_present),
		.dropped_full (out_port.dropped_full),
		.held_count   (out_port.held_count)
	);

endmodule

[design/hks_checker.sv]
// hks_checker: port level checks of the held key set unit, bound to the top level
// depends on hks_pkg and held_key_set_unit

module hks_checker import hks_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   was_present,
	input logic                   dropped_full,
	input logic [COUNT_OUT_W-1:0] held_count
);

	localparam logic [COUNT_OUT_W-1:0] CAP_OUT = COUNT_OUT_W'(CAPACITY);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(held_count))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("event taken while previous one in progress");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_full |-> !was_present && held_count == CAP_OUT)
		else $error("dropped press with free room or held key");

	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##2 out_valid)
		else $error("result missing after event");

endmodule

bind held_key_set_unit hks_checker #(
	.CAPACITY (CAPACITY)
) u_hks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_port.valid),
	.in_ready     (in_port.ready),
	.out_valid    (out_port.valid),
	.out_ready    (out_port.ready),
	.was_present  (out_port.was_present),
	.dropped_full (out_port.dropped_full),
	.held_count   (out_port.held_count)
);
